@@ hdl/opat_pkg.sv @@
// Shared types, constants and helper functions for the order pattern histogram.
// No dependencies; imported by every module of the block.
package opat_pkg;

   localparam int NEIGH_MAX        = 4;
   localparam int NIDX_W           = 2;
   localparam int DATA_W           = 16;
   localparam int BIN_W            = 3;
   localparam int ADDR_W           = 8;
   localparam int PAT_W            = 5;
   localparam int WGT_W            = 3;
   localparam int CNT_W            = 2;
   localparam int REQ_DATA_W       = 80;
   localparam int RSP_DATA_W       = 24;
   localparam int SPATIAL_BINS_DEF = 6;
   localparam int NEIGHBOURS_DEF   = 4;

   localparam logic [DATA_W-1:0] THR_RESET = 16'd1285;
   localparam logic [DATA_W-1:0] ENTRY_MAX = 16'hFFFF;

   localparam logic ACT_ACCUM = 1'b0;
   localparam logic ACT_READ  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAIRS,
      ST_RANK,
      ST_FETCH,
      ST_UPDATE
   } opat_state_type;

   typedef struct packed {
      logic              clear;
      logic              step;
      logic [NIDX_W-1:0] idx_a;
      logic [NIDX_W-1:0] idx_b;
   } opat_pair_ctrl_type;

   function automatic int factorial(int n);
      int f;
      f = 1;
      for (int k = 2; k <= NEIGH_MAX; k++) begin
         if (k <= n) f = f * k;
      end
      return f;
   endfunction

   // place value of a Lehmer digit at sorted position pos: (n-1-pos)!
   function automatic logic [PAT_W-1:0] fact_weight(int n, logic [NIDX_W-1:0] pos);
      int k;
      k = n - 1 - int'(pos);
      if (k < 0) return '0;
      return PAT_W'(factorial(k));
   endfunction

endpackage

@@ hdl/opat_pair_unit.sv @@
// Shared pair compare unit: one subtract, abs and threshold compare per cycle.
// Accumulates rank positions, Lehmer digits and pair weight. Uses opat_pkg.
module opat_pair_unit #(
   parameter int NEIGHBOURS = opat_pkg::NEIGHBOURS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  opat_pkg::opat_pair_ctrl_type   ctrl,
   input  logic [opat_pkg::DATA_W-1:0]    oper_a,
   input  logic [opat_pkg::DATA_W-1:0]    oper_b,
   input  logic [opat_pkg::DATA_W-1:0]    threshold,
   output logic [opat_pkg::PAT_W-1:0]     pattern,
   output logic [opat_pkg::WGT_W-1:0]     weight
);
   import opat_pkg::*;

   logic [CNT_W-1:0]  pos_ff [NEIGH_MAX];
   logic [CNT_W-1:0]  pos_in [NEIGH_MAX];
   logic [CNT_W-1:0]  cnt_ff [NEIGH_MAX];
   logic [CNT_W-1:0]  cnt_in [NEIGH_MAX];
   logic [WGT_W-1:0]  weight_ff;
   logic [WGT_W-1:0]  weight_in;
   logic [DATA_W:0]   diff;
   logic [DATA_W-1:0] abs_diff;
   logic              a_gt_b;
   logic [PAT_W-1:0]  pat_sum;

   always_comb begin
      diff     = {1'b0, oper_a} - {1'b0, oper_b};
      a_gt_b   = !diff[DATA_W] && (diff[DATA_W-1:0] != '0);
      abs_diff = diff[DATA_W] ? (~diff[DATA_W-1:0] + 1'b1) : diff[DATA_W-1:0];

      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      weight_in = weight_ff;
      if (ctrl.clear) begin
         for (int k = 0; k < NEIGH_MAX; k++) begin
            pos_in[k] = '0;
            cnt_in[k] = '0;
         end
         weight_in = '0;
      end else if (ctrl.step) begin
         // idx_a < idx_b; the later index goes first only if strictly smaller
         if (a_gt_b) begin
            pos_in[ctrl.idx_a] = pos_ff[ctrl.idx_a] + 1'b1;
            cnt_in[ctrl.idx_b] = cnt_ff[ctrl.idx_b] + 1'b1;
         end else begin
            pos_in[ctrl.idx_b] = pos_ff[ctrl.idx_b] + 1'b1;
         end
         if (abs_diff > threshold) weight_in = weight_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < NEIGH_MAX; k++) begin
            pos_ff[k] <= '0;
            cnt_ff[k] <= '0;
         end
         weight_ff <= '0;
      end else begin
         pos_ff    <= pos_in;
         cnt_ff    <= cnt_in;
         weight_ff <= weight_in;
      end
   end

   always_comb begin
      pat_sum = '0;
      for (int k = 0; k < NEIGH_MAX; k++) begin
         pat_sum = pat_sum
                 + PAT_W'({{(PAT_W-CNT_W){1'b0}}, cnt_ff[k]} * fact_weight(NEIGHBOURS, pos_ff[k]));
      end
   end

   assign pattern = pat_sum;
   assign weight  = weight_ff;

endmodule

@@ hdl/opat_hist_mem.sv @@
// Histogram entry store: one write and one registered read per cycle.
// Per-entry valid bits give all-zero contents right after reset. Uses opat_pkg.
module opat_hist_mem #(
   parameter int DEPTH = opat_pkg::SPATIAL_BINS_DEF * 24,
   parameter int IDX_W = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        rd_en,
   input  logic [IDX_W-1:0]            rd_idx,
   input  logic                        wr_en,
   input  logic [IDX_W-1:0]            wr_idx,
   input  logic [opat_pkg::DATA_W-1:0] wr_data,
   output logic [opat_pkg::DATA_W-1:0] rd_data
);
   import opat_pkg::*;

   logic [DATA_W-1:0] hist_ff [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   logic [DATA_W-1:0] rd_data_ff;
   logic              rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) hist_ff[wr_idx] <= wr_data;
      if (rd_en) rd_data_ff <= hist_ff[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) valid_ff[wr_idx] <= 1'b1;
         if (rd_en) rd_valid_ff <= valid_ff[rd_idx];
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule

@@ hdl/order_pattern_histogram_unit.sv @@
// Order pattern histogram: top level with sequencer, operand select and result register.
// Accumulate: the shared compare unit takes one pair per cycle, then the pattern is ranked,
// the entry fetched and updated, waiting for a free response slot; then back to idle.
// Read and clear: entry fetched, returned and cleared. Requests are taken only in idle.
// Synchronous reset: histogram reads as zero at once, threshold returns to 1285.
// Depends on opat_pkg, opat_pair_unit, opat_hist_mem.
module order_pattern_histogram_unit #(
   parameter int SPATIAL_BINS = opat_pkg::SPATIAL_BINS_DEF,
   parameter int NEIGHBOURS   = opat_pkg::NEIGHBOURS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // neigh0[15:0] neigh1[31:16] neigh2[47:32] neigh3[63:48]
   // spatial_bin[66:64] read_address[74:67] zero[79:75]
   input  logic [opat_pkg::REQ_DATA_W-1:0] req_tdata,
   // action[0]
   input  logic                            req_tuser,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // pattern_index[4:0] pair_weight[7:5] entry_value[23:8]
   output logic [opat_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_we,
   input  logic [opat_pkg::DATA_W-1:0]     csr_wdata
);
   import opat_pkg::*;

   localparam int PCOUNT = factorial(NEIGHBOURS);
   localparam int DEPTH  = SPATIAL_BINS * PCOUNT;
   localparam int MIDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [NIDX_W-1:0] LAST_IDX = NIDX_W'(NEIGHBOURS - 1);
   localparam logic [NIDX_W-1:0] LAST_I   = NIDX_W'(NEIGHBOURS - 2);

   opat_state_type     state_ff, state_in;
   logic               action_ff, action_in;
   logic [DATA_W-1:0]  n0_ff, n0_in, n1_ff, n1_in, n2_ff, n2_in, n3_ff, n3_in;
   logic [BIN_W-1:0]   bin_ff, bin_in;
   logic [ADDR_W-1:0]  addr_ff, addr_in;
   logic               in_range_ff, in_range_in;
   logic [NIDX_W-1:0]  i_ff, i_in, j_ff, j_in;
   logic [PAT_W-1:0]   pattern_ff, pattern_in;
   logic [DATA_W-1:0]  thr_ff;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   opat_pair_ctrl_type pair_ctrl;
   logic [DATA_W-1:0]  oper_a, oper_b;
   logic [PAT_W-1:0]   pair_pattern;
   logic [WGT_W-1:0]   pair_weight;
   logic               mem_rd_en, mem_wr_en;
   logic [DATA_W-1:0]  mem_wr_data, mem_rd_data;
   logic [BIN_W-1:0]   bin_sat;
   logic [DATA_W:0]    acc_sum;
   logic [DATA_W-1:0]  entry_val;

   function automatic logic [DATA_W-1:0] pick(logic [NIDX_W-1:0] idx, logic [DATA_W-1:0] v0,
                                              logic [DATA_W-1:0] v1, logic [DATA_W-1:0] v2,
                                              logic [DATA_W-1:0] v3);
      case (idx)
         2'd0:    return v0;
         2'd1:    return v1;
         2'd2:    return v2;
         default: return v3;
      endcase
   endfunction

   assign oper_a = pick(i_ff, n0_ff, n1_ff, n2_ff, n3_ff);
   assign oper_b = pick(j_ff, n0_ff, n1_ff, n2_ff, n3_ff);

   assign bin_sat = ({1'b0, bin_ff} >= (BIN_W+1)'(SPATIAL_BINS)) ? BIN_W'(SPATIAL_BINS - 1)
                                                                  : bin_ff;
   assign acc_sum = {1'b0, mem_rd_data} + (DATA_W+1)'(pair_weight);

   always_comb begin
      state_in     = state_ff;
      action_in    = action_ff;
      n0_in        = n0_ff;
      n1_in        = n1_ff;
      n2_in        = n2_ff;
      n3_in        = n3_ff;
      bin_in       = bin_ff;
      addr_in      = addr_ff;
      in_range_in  = in_range_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      pattern_in   = pattern_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      req_tready   = 1'b0;
      pair_ctrl    = '0;
      pair_ctrl.idx_a = i_ff;
      pair_ctrl.idx_b = j_ff;
      mem_rd_en    = 1'b0;
      mem_wr_en    = 1'b0;
      mem_wr_data  = '0;
      entry_val    = '0;

      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               action_in       = req_tuser;
               n0_in           = req_tdata[15:0];
               n1_in           = req_tdata[31:16];
               n2_in           = req_tdata[47:32];
               n3_in           = req_tdata[63:48];
               bin_in          = req_tdata[66:64];
               pattern_in      = '0;
               i_in            = '0;
               j_in            = NIDX_W'(1);
               pair_ctrl.clear = 1'b1;
               if (req_tuser == ACT_READ) begin
                  addr_in     = req_tdata[74:67];
                  in_range_in = (9'(req_tdata[74:67]) < 9'(DEPTH));
                  state_in    = ST_FETCH;
               end else begin
                  state_in = ST_PAIRS;
               end
            end
         end
         ST_PAIRS: begin
            pair_ctrl.step = 1'b1;
            if (j_ff == LAST_IDX) begin
               if (i_ff == LAST_I) begin
                  state_in = ST_RANK;
               end else begin
                  i_in = i_ff + 1'b1;
                  j_in = i_ff + NIDX_W'(2);
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_RANK: begin
            pattern_in  = pair_pattern;
            addr_in     = ADDR_W'(bin_sat) * ADDR_W'(PCOUNT) + ADDR_W'(pair_pattern);
            in_range_in = 1'b1;
            state_in    = ST_FETCH;
         end
         ST_FETCH: begin
            mem_rd_en = in_range_ff;
            state_in  = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (!in_range_ff) begin
               entry_val = '0;
            end else if (action_ff == ACT_READ) begin
               entry_val = mem_rd_data;
            end else begin
               entry_val = acc_sum[DATA_W] ? ENTRY_MAX : acc_sum[DATA_W-1:0];
            end
            if (!rsp_valid_ff || rsp_tready) begin
               mem_wr_en    = in_range_ff;
               mem_wr_data  = (action_ff == ACT_READ) ? '0 : entry_val;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {entry_val, pair_weight, pattern_ff};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         thr_ff       <= THR_RESET;
         i_ff         <= '0;
         j_ff         <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         if (csr_we) thr_ff <= csr_wdata;
      end
   end

   always_ff @(posedge clock) begin
      action_ff   <= action_in;
      n0_ff       <= n0_in;
      n1_ff       <= n1_in;
      n2_ff       <= n2_in;
      n3_ff       <= n3_in;
      bin_ff      <= bin_in;
      addr_ff     <= addr_in;
      in_range_ff <= in_range_in;
      pattern_ff  <= pattern_in;
      rsp_data_ff <= rsp_data_in;
   end

   opat_pair_unit #(
      .NEIGHBOURS (NEIGHBOURS)
   ) u_pair (
      .clock     (clock),
      .reset     (reset),
      .ctrl      (pair_ctrl),
      .oper_a    (oper_a),
      .oper_b    (oper_b),
      .threshold (thr_ff),
      .pattern   (pair_pattern),
      .weight    (pair_weight)
   );

   opat_hist_mem #(
      .DEPTH (DEPTH),
      .IDX_W (MIDX_W)
   ) u_mem (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (mem_rd_en),
      .rd_idx  (addr_ff[MIDX_W-1:0]),
      .wr_en   (mem_wr_en),
      .wr_idx  (addr_ff[MIDX_W-1:0]),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
